FILE: src/nps_pkg.sv
// ============================================================================
// nps_pkg: shared types and constants for the priority scheduler
// Job and result transaction layouts, queue sizing and scheduler states.
// ============================================================================
package nps_pkg;

    // default table depth
    localparam int MAX_JOBS_DEF = 16;

    // field widths
    localparam int ARR_W  = 16;
    localparam int LEN_W  = 16;
    localparam int PRI_W  = 16;
    localparam int ID_W   = 5;
    localparam int TIME_W = 21;
    localparam int SUM_W  = 25;

    // job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // one incoming job transaction
    typedef struct packed {
        logic [ARR_W-1:0]        arrival;
        logic [LEN_W-1:0]        burst;
        logic signed [PRI_W-1:0] prio;
        logic                    last_job;
    } job_in_t;

    // one stored table entry
    typedef struct packed {
        logic [ARR_W-1:0]        arr;
        logic [LEN_W-1:0]        len;
        logic signed [PRI_W-1:0] pri;
    } job_entry_t;

    // one result transaction
    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] wait_ticks;
        logic [TIME_W-1:0] turnaround_ticks;
        logic [SUM_W-1:0]  total_wait;
        logic [SUM_W-1:0]  total_turnaround;
        logic              final_result;
    } result_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } sched_state_t;

endpackage

FILE: src/nonpreemptive_priority_scheduler.sv
// ============================================================================
// nonpreemptive_priority_scheduler: non-preemptive priority scheduling
// Loads a set of jobs, then emits one timing result per job in run order.
// ============================================================================
// Usage:
//   Job channel: a job transaction (arrival, burst, prio, last_job) is taken
//   when start is high and busy is low. Jobs pass a two-entry queue and are
//   written to the job table at one per cycle while no schedule runs. A job
//   beyond MAX_JOBS is dropped; last_job still starts the schedule.
//   Result channel: strobe is high for one cycle per result; the receiver
//   must take it then. The final result of a set carries the wait and
//   turnaround totals and final_result; other results carry zero totals.
//   Schedule: a round scans the n stored entries through the registered
//   table read, then runs the pick in the emit state. A round with no
//   arrived job rescans after the clock jump to the earliest pending arrival;
//   the clock starts at zero, so the first round jumps unless a job arrives
//   at zero. During a schedule the queue fills and busy holds further jobs
//   off.
//   Reset: clears queue, job count, done flags, clock and sums, not the table.
// ============================================================================
module nonpreemptive_priority_scheduler #(
    parameter int MAX_JOBS = nps_pkg::MAX_JOBS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  nps_pkg::job_in_t  job,
    output logic              busy,
    output logic              strobe,
    output nps_pkg::result_t  result
);

    logic             q_valid;
    logic             q_pop;
    nps_pkg::job_in_t q_data;

    // intake and queue
    nps_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .job     (job),
        .busy    (busy),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    // table and scheduling engine
    nps_sched #(
        .MAX_JOBS (MAX_JOBS)
    ) u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

FILE: src/nps_front.sv
// ============================================================================
// nps_front: job intake and queue
// Accepts job transactions and holds them in a short queue for the back end.
// ============================================================================
module nps_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  nps_pkg::job_in_t  job,
    output logic              busy,
    output logic              q_valid,
    output nps_pkg::job_in_t  q_data,
    input  logic              q_pop
);

    nps_pkg::job_in_t                q_mem [nps_pkg::QDEPTH];
    logic [nps_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [nps_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [nps_pkg::QCNT_W-1:0]      q_cnt_reg, q_cnt_next;
    logic                            push;
    logic                            pop;

    // handshake
    assign busy    = (q_cnt_reg == nps_pkg::QCNT_W'(nps_pkg::QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (q_cnt_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_data  = q_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + nps_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + nps_pkg::QPTR_W'(1) : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg;
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + nps_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - nps_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= job;
        end
    end

endmodule

FILE: src/nps_sched.sv
// ============================================================================
// nps_sched: job table and scheduling engine
// Stores queued jobs, then per round scans the table for the best ready job,
// runs it and emits its times.
// ============================================================================
module nps_sched #(
    parameter int MAX_JOBS = nps_pkg::MAX_JOBS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  nps_pkg::job_in_t  q_data,
    output logic              q_pop,
    output logic              strobe,
    output nps_pkg::result_t  result
);

    localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int CLK_W = nps_pkg::ARR_W + CNT_W;
    localparam int SUM_W = nps_pkg::SUM_W;

    // job table
    nps_pkg::job_entry_t mem [MAX_JOBS];
    nps_pkg::job_entry_t rd_data_reg;
    nps_pkg::job_entry_t wr_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;

    nps_pkg::sched_state_t state_reg, state_next;

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CNT_W-1:0]          round_reg, round_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [MAX_JOBS-1:0]       done_reg, done_next;
    logic [CLK_W-1:0]          clk_reg, clk_next;
    logic [nps_pkg::ARR_W-1:0] min_arr_reg, min_arr_next;
    logic                      min_found_reg, min_found_next;
    logic                      best_found_reg, best_found_next;
    logic [IDX_W-1:0]          best_idx_reg, best_idx_next;
    logic [nps_pkg::ARR_W-1:0] best_arr_reg, best_arr_next;
    logic [nps_pkg::LEN_W-1:0] best_len_reg, best_len_next;
    logic signed [nps_pkg::PRI_W-1:0] best_pri_reg, best_pri_next;
    logic [CLK_W-1:0]          wt_reg, wt_next;
    logic [SUM_W-1:0]          wsum_reg, wsum_next;
    logic [SUM_W-1:0]          tsum_reg, tsum_next;
    logic                      strobe_reg, strobe_next;
    nps_pkg::result_t          result_reg, result_next;

    // scan and emit helpers
    logic             pending;
    logic             in_time;
    logic             better;
    logic             scan_end;
    logic [CLK_W-1:0] fin;
    logic [CLK_W-1:0] ta;
    logic [SUM_W-1:0] wsum_add;
    logic [SUM_W-1:0] tsum_add;
    logic [CNT_W-1:0] round_inc;
    logic             last_round;

    assign rd_addr = idx_reg[IDX_W-1:0];
    assign wr_addr = cnt_reg[IDX_W-1:0];
    assign wr_data = '{arr: q_data.arrival, len: q_data.burst, pri: q_data.prio};
    assign q_pop   = (state_reg == nps_pkg::ST_LOAD) && q_valid;
    assign wr_en   = q_pop && (cnt_reg < CNT_W'(MAX_JOBS));

    // candidate compare for the entry coming out of the table
    assign pending  = !done_reg[rd_idx_reg];
    assign in_time  = CLK_W'(rd_data_reg.arr) <= clk_reg;
    assign better   = !best_found_reg || (rd_data_reg.pri > best_pri_reg) ||
                      ((rd_data_reg.pri == best_pri_reg) && (rd_data_reg.arr < best_arr_reg));
    assign scan_end = (idx_reg == cnt_reg) && !rd_vld_reg;

    // run the chosen job
    assign fin        = clk_reg + CLK_W'(best_len_reg);
    assign ta         = wt_reg + CLK_W'(best_len_reg);
    assign wsum_add   = wsum_reg + SUM_W'(wt_reg);
    assign tsum_add   = tsum_reg + SUM_W'(ta);
    assign round_inc  = round_reg + CNT_W'(1);
    assign last_round = (round_inc == cnt_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        round_next      = round_reg;
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        done_next       = done_reg;
        clk_next        = clk_reg;
        min_arr_next    = min_arr_reg;
        min_found_next  = min_found_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_arr_next   = best_arr_reg;
        best_len_next   = best_len_reg;
        best_pri_next   = best_pri_reg;
        wt_next         = wt_reg;
        wsum_next       = wsum_reg;
        tsum_next       = tsum_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;

        case (state_reg)
            nps_pkg::ST_LOAD:
            begin
                if (q_pop)
                begin
                    if (wr_en)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    // last job: start a schedule with the clock at zero,
                    // the idle jump moves it to the earliest arrival
                    if (q_data.last_job)
                    begin
                        state_next      = nps_pkg::ST_SCAN;
                        round_next      = '0;
                        done_next       = '0;
                        clk_next        = '0;
                        wsum_next       = '0;
                        tsum_next       = '0;
                        idx_next        = '0;
                        min_found_next  = 1'b0;
                        best_found_next = 1'b0;
                    end
                end
            end

            nps_pkg::ST_SCAN:
            begin
                // issue reads
                if (idx_reg != cnt_reg)
                begin
                    idx_next    = idx_reg + CNT_W'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = idx_reg[IDX_W-1:0];
                end
                // evaluate returned entry
                if (rd_vld_reg && pending)
                begin
                    if (!min_found_reg || (rd_data_reg.arr < min_arr_reg))
                    begin
                        min_arr_next   = rd_data_reg.arr;
                        min_found_next = 1'b1;
                    end
                    if (in_time && better)
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_arr_next   = rd_data_reg.arr;
                        best_len_next   = rd_data_reg.len;
                        best_pri_next   = rd_data_reg.pri;
                    end
                end
                if (scan_end)
                begin
                    if (best_found_reg)
                    begin
                        wt_next    = clk_reg - CLK_W'(best_arr_reg);
                        state_next = nps_pkg::ST_EMIT;
                    end
                    else
                    begin
                        // idle: jump to earliest pending arrival and rescan
                        clk_next        = CLK_W'(min_arr_reg);
                        idx_next        = '0;
                        min_found_next  = 1'b0;
                        best_found_next = 1'b0;
                    end
                end
            end

            nps_pkg::ST_EMIT:
            begin
                clk_next                 = fin;
                done_next[best_idx_reg]  = 1'b1;
                wsum_next                = wsum_add;
                tsum_next                = tsum_add;
                round_next               = round_inc;
                strobe_next              = 1'b1;
                result_next.job_id       = nps_pkg::ID_W'({1'b0, best_idx_reg} +
                                                          (IDX_W + 1)'(1));
                result_next.finish_time      = nps_pkg::TIME_W'(fin);
                result_next.wait_ticks       = nps_pkg::TIME_W'(wt_reg);
                result_next.turnaround_ticks = nps_pkg::TIME_W'(ta);
                result_next.total_wait       = last_round ? wsum_add : '0;
                result_next.total_turnaround = last_round ? tsum_add : '0;
                result_next.final_result     = last_round;
                idx_next        = '0;
                min_found_next  = 1'b0;
                best_found_next = 1'b0;
                if (last_round)
                begin
                    state_next = nps_pkg::ST_LOAD;
                    cnt_next   = '0;
                    done_next  = '0;
                end
                else
                begin
                    state_next = nps_pkg::ST_SCAN;
                end
            end

            default:
            begin
                state_next = nps_pkg::ST_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nps_pkg::ST_LOAD;
            cnt_reg        <= '0;
            round_reg      <= '0;
            idx_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            done_reg       <= '0;
            clk_reg        <= '0;
            min_found_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            wsum_reg       <= '0;
            tsum_reg       <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            round_reg      <= round_next;
            idx_reg        <= idx_next;
            rd_vld_reg     <= rd_vld_next;
            done_reg       <= done_next;
            clk_reg        <= clk_next;
            min_found_reg  <= min_found_next;
            best_found_reg <= best_found_next;
            wsum_reg       <= wsum_next;
            tsum_reg       <= tsum_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        min_arr_reg  <= min_arr_next;
        best_idx_reg <= best_idx_next;
        best_arr_reg <= best_arr_next;
        best_len_reg <= best_len_next;
        best_pri_reg <= best_pri_next;
        wt_reg       <= wt_next;
        result_reg   <= result_next;
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // checks
    a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == nps_pkg::ST_EMIT))
        else $error("result strobe without a run cycle");

    a_final_clears_set: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.final_result) |->
            (state_reg == nps_pkg::ST_LOAD && cnt_reg == '0 && done_reg == '0))
        else $error("job set not cleared after final result");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == nps_pkg::ST_SCAN))
        else $error("table read returned outside a scan");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nps_pkg::ST_SCAN) |-> (round_reg < cnt_reg))
        else $error("round count ran past job count");

    a_pick_undone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nps_pkg::ST_EMIT) |-> !done_reg[best_idx_reg])
        else $error("picked a job that already ran");

endmodule
